>>> design/c16_pkg.sv
package c16_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    localparam logic [3:0] OP_ADD  = 4'h0;
    localparam logic [3:0] OP_SUB  = 4'h1;
    localparam logic [3:0] OP_AND  = 4'h2;
    localparam logic [3:0] OP_OR   = 4'h3;
    localparam logic [3:0] OP_XOR  = 4'h4;
    localparam logic [3:0] OP_CMP  = 4'h5;
    localparam logic [3:0] OP_MOV  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_SLL  = 4'h8;
    localparam logic [3:0] OP_SLR  = 4'h9;
    localparam logic [3:0] OP_SRL  = 4'ha;
    localparam logic [3:0] OP_SRA  = 4'hb;
    localparam logic [3:0] OP_OUT  = 4'hd;
    localparam logic [3:0] OP_CMPI = 4'he;
    localparam logic [3:0] OP_HLT  = 4'hf;

    localparam logic [1:0] CLS_LD  = 2'd0;
    localparam logic [1:0] CLS_ST  = 2'd1;
    localparam logic [1:0] CLS_BR  = 2'd2;
    localparam logic [1:0] CLS_REG = 2'd3;

    localparam logic [2:0] SUB_LI  = 3'd0;
    localparam logic [2:0] SUB_B   = 3'd4;
    localparam logic [2:0] SUB_BC  = 3'd7;

    localparam logic [2:0] BC_BE  = 3'd0;
    localparam logic [2:0] BC_BLT = 3'd1;
    localparam logic [2:0] BC_BLE = 3'd2;
    localparam logic [2:0] BC_BNE = 3'd3;
    localparam logic [2:0] BC_BAL = 3'd4;
    localparam logic [2:0] BC_BR  = 3'd5;

    localparam logic [2:0] LINK_REG = 3'd6;

    typedef struct packed {
        logic [15:0] value;
        logic        wr;
        logic [3:0]  flags;
        logic        fl_wr;
        logic        halt;
        logic        out_v;
        logic        ill;
    } t_alu_res;

endpackage

>>> design/c16_alu.sv
module c16_alu (
    input  logic [15:0]      i_code,
    input  logic [15:0]      i_x,
    input  logic [15:0]      i_y,
    output c16_pkg::t_alu_res o_res
);

    logic [3:0]  op;
    logic [3:0]  sh;
    logic [15:0] d4;
    logic [15:0] rhs;
    logic        is_sub;
    logic [16:0] sum;
    logic [15:0] r;
    logic [31:0] rot;
    logic [31:0] sra;
    logic        v;

    assign op = i_code[7:4];
    assign sh = i_code[3:0];
    assign d4 = {{12{sh[3]}}, sh};
    assign is_sub = (op == c16_pkg::OP_SUB) || (op == c16_pkg::OP_CMP)
                 || (op == c16_pkg::OP_CMPI);
    assign rhs = (op == c16_pkg::OP_CMPI) ? d4 : i_y;
    assign sum = {1'b0, i_x} + (is_sub ? {1'b0, (~rhs) + 16'd1} : {1'b0, rhs});
    assign r = sum[15:0];
    assign v = is_sub ? ((i_x[15] ^ rhs[15]) & (i_x[15] ^ r[15]))
                      : (~(i_x[15] ^ rhs[15]) & (i_x[15] ^ r[15]));
    assign rot = {i_x, i_x} << sh;
    assign sra = {{16{i_x[15]}}, i_x} >> sh;

    always_comb begin
        o_res = '0;
        case (op)
            c16_pkg::OP_ADD, c16_pkg::OP_SUB: begin
                o_res.value = r;
                o_res.wr = 1'b1;
                o_res.fl_wr = 1'b1;
                o_res.flags = {v, sum[16], r == 16'd0, r[15]};
            end
            c16_pkg::OP_CMP, c16_pkg::OP_CMPI: begin
                o_res.fl_wr = 1'b1;
                o_res.flags = {v, sum[16], r == 16'd0, r[15]};
            end
            c16_pkg::OP_AND, c16_pkg::OP_OR, c16_pkg::OP_XOR, c16_pkg::OP_MOV: begin
                case (op)
                    c16_pkg::OP_AND: o_res.value = i_x & i_y;
                    c16_pkg::OP_OR:  o_res.value = i_x | i_y;
                    c16_pkg::OP_XOR: o_res.value = i_x ^ i_y;
                    default:         o_res.value = i_y;
                endcase
                o_res.wr = 1'b1;
                o_res.fl_wr = 1'b1;
                o_res.flags = {2'b00, o_res.value == 16'd0, o_res.value[15]};
            end
            c16_pkg::OP_ADDI: begin
                o_res.value = i_x + d4;
                o_res.wr = 1'b1;
            end
            c16_pkg::OP_SLL: begin
                o_res.value = i_x << sh;
                o_res.wr = 1'b1;
            end
            c16_pkg::OP_SLR: begin
                o_res.value = rot[31:16];
                o_res.wr = 1'b1;
            end
            c16_pkg::OP_SRL: begin
                o_res.value = i_x >> sh;
                o_res.wr = 1'b1;
            end
            c16_pkg::OP_SRA: begin
                o_res.value = sra[15:0];
                o_res.wr = 1'b1;
            end
            c16_pkg::OP_OUT: o_res.out_v = 1'b1;
            c16_pkg::OP_HLT: o_res.halt = 1'b1;
            default: o_res.ill = 1'b1;
        endcase
    end

endmodule

>>> design/cpu16_instruction_step_top.sv
// cpu16_instruction_step_top: small 16-bit processor driven one command at a time.
// input channel (i_valid/o_ready) carries cmd, addr, data; every beat gives
// exactly one beat on the output channel (o_valid/i_ready) with pc, halted,
// out_valid/out_value, reg_value, flags and illegal.
// cmd load writes a memory word, cmd exec runs the instruction at pc, cmd read
// returns register addr mod 8; other codes only report the state.
// throughput: one command per cycle for load, read and commands that do not
// touch memory data, while the output slot is free; exec holds off new commands
// through a fetch read of the single-port memory, then execute with an optional
// LD/ST data access; LD adds a step: fetch, data read, register write.
// latency: result is registered; it appears in the cycle after a load/read beat,
// after S_EXEC for an exec and after S_EXEC and S_LD for an LD.
// the output register holds the result until taken; a new command is taken only
// when the output slot is free or being emptied in the same cycle.
// reset (synchronous, active low) clears registers, flags, halt and pc;
// memory is undefined until written.
// i_cfg_we with i_cfg_data loads the program counter.
module cpu16_instruction_step_top #(
    parameter int MEM_ADDR_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [14:0] i_addr,
    input  logic [15:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [14:0] o_pc,
    output logic        o_halted,
    output logic        o_out_valid,
    output logic [15:0] o_out_value,
    output logic [15:0] o_reg_value,
    output logic [3:0]  o_flags,
    output logic        o_illegal
);

    localparam int AW = MEM_ADDR_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LD   = 3'b100
    } t_state;

    logic [15:0] mem [2**AW];
    logic [15:0] r_mem_q;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wd;

    logic [15:0] r_regs [8];
    logic [AW-1:0] r_pc, n_pc;
    logic [3:0]  r_flags, n_flags;
    logic        r_halt, n_halt;
    t_state      r_state, n_state;
    logic [2:0]  r_ld_ra;

    logic        r_ov, n_ov;
    logic [15:0] r_oval, n_oval;
    logic [15:0] r_rv, n_rv;
    logic        r_ill, n_ill;
    logic        n_ovalid;
    logic        reg_we;
    logic [2:0]  reg_wa;
    logic [15:0] reg_wd;

    logic        slot_free;
    logic        in_fire;
    logic [1:0]  cls;
    logic [2:0]  ra, rb;
    logic [15:0] d8, x, y;
    logic [AW-1:0] npc;
    logic [AW-1:0] daddr;
    logic        take;
    c16_pkg::t_alu_res alu;
    logic [14:0] pc_ext;

    assign slot_free = !o_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE) && slot_free;
    assign in_fire   = i_valid && o_ready;

    assign cls = r_mem_q[15:14];
    assign ra  = r_mem_q[13:11];
    assign rb  = r_mem_q[10:8];
    assign d8  = {{8{r_mem_q[7]}}, r_mem_q[7:0]};
    assign x   = r_regs[rb];
    assign y   = r_regs[ra];
    assign npc = r_pc + AW'(1);
    assign daddr = AW'(x + d8);

    c16_alu u_alu (
        .i_code (r_mem_q),
        .i_x    (x),
        .i_y    (y),
        .o_res  (alu)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_mem_q <= mem[mem_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_flags  = r_flags;
        n_halt   = r_halt;
        n_ov     = 1'b0;
        n_oval   = 16'd0;
        n_rv     = 16'd0;
        n_ill    = 1'b0;
        n_ovalid = 1'b0;
        reg_we   = 1'b0;
        reg_wa   = rb;
        reg_wd   = alu.value;
        mem_we   = 1'b0;
        mem_addr = AW'(i_addr);
        mem_wd   = i_data;
        take     = 1'b0;
        case (r_state)
            S_IDLE: begin
                mem_addr = r_pc;
                if (in_fire) begin
                    case (c16_pkg::t_cmd'(i_cmd))
                        c16_pkg::CMD_LOAD: begin
                            mem_addr = AW'(i_addr);
                            mem_we   = 1'b1;
                            n_ovalid = 1'b1;
                        end
                        c16_pkg::CMD_EXEC: begin
                            if (r_halt) n_ovalid = 1'b1;
                            else n_state = S_EXEC;
                        end
                        c16_pkg::CMD_READ: begin
                            n_rv     = r_regs[i_addr[2:0]];
                            n_ovalid = 1'b1;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            S_EXEC: begin
                n_pc     = npc;
                n_ovalid = 1'b1;
                mem_addr = daddr;
                case (cls)
                    c16_pkg::CLS_LD: begin
                        n_state  = S_LD;
                        n_ovalid = 1'b0;
                    end
                    c16_pkg::CLS_ST: begin
                        mem_we = 1'b1;
                        mem_wd = y;
                        n_state = S_IDLE;
                    end
                    c16_pkg::CLS_BR: begin
                        n_state = S_IDLE;
                        case (ra)
                            c16_pkg::SUB_LI: begin
                                reg_we = 1'b1;
                                reg_wd = d8;
                            end
                            c16_pkg::SUB_B:
                                n_pc = npc + AW'({{5{r_mem_q[10]}}, r_mem_q[10:0]});
                            c16_pkg::SUB_BC: begin
                                case (rb)
                                    c16_pkg::BC_BE:  take = r_flags[1];
                                    c16_pkg::BC_BLT: take = r_flags[0] != r_flags[3];
                                    c16_pkg::BC_BLE:
                                        take = r_flags[1] || (r_flags[0] != r_flags[3]);
                                    c16_pkg::BC_BNE: take = !r_flags[1];
                                    c16_pkg::BC_BAL: begin
                                        take   = 1'b1;
                                        reg_we = 1'b1;
                                        reg_wa = c16_pkg::LINK_REG;
                                        reg_wd = 16'(npc);
                                    end
                                    c16_pkg::BC_BR:
                                        n_pc = AW'(r_regs[c16_pkg::LINK_REG]);
                                    default: n_ill = 1'b1;
                                endcase
                                if (take) n_pc = npc + AW'(d8);
                            end
                            default: n_ill = 1'b1;
                        endcase
                    end
                    default: begin
                        n_state = S_IDLE;
                        reg_we  = alu.wr;
                        if (alu.fl_wr) n_flags = alu.flags;
                        if (alu.halt) n_halt = 1'b1;
                        n_ov   = alu.out_v;
                        n_oval = alu.out_v ? y : 16'd0;
                        n_ill  = alu.ill;
                    end
                endcase
            end
            S_LD: begin
                mem_addr = r_pc;
                reg_we   = 1'b1;
                reg_wa   = r_ld_ra;
                reg_wd   = r_mem_q;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_flags <= '0;
            r_halt  <= 1'b0;
            o_valid <= 1'b0;
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_halt  <= n_halt;
            r_pc    <= i_cfg_we ? AW'(i_cfg_data) : n_pc;
            if (reg_we) r_regs[reg_wa] <= reg_wd;
            if (n_ovalid) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) r_ld_ra <= ra;
        if (n_ovalid) begin
            r_ov   <= n_ov;
            r_oval <= n_oval;
            r_rv   <= n_rv;
            r_ill  <= n_ill;
        end
    end

    assign pc_ext      = 15'(r_pc);
    assign o_pc        = pc_ext;
    assign o_halted    = r_halt;
    assign o_out_valid = r_ov;
    assign o_out_value = r_oval;
    assign o_reg_value = r_rv;
    assign o_flags     = r_flags;
    assign o_illegal   = r_ill;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("beat accepted while instruction in flight");
    a_exec_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE || r_state == S_LD))
        else $error("exec did not complete");
    a_ld_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD) |=> o_valid && r_state == S_IDLE)
        else $error("load gave no result");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) && $past(i_rst_n) |-> r_halt)
        else $error("halt cleared");

endmodule
